// File: hdl/bwbp_pkg.sv
// Shared types and constants for the multi-channel Butterworth bandpass biquad.
// Used by bwbp_calc, bwbp_ofifo and butterworth_bandpass_biquad.
// No dependencies.
package bwbp_pkg;

    // Fixed field widths
    localparam int CHAN_BITS    = 3;
    localparam int COEF_BITS    = 24;
    localparam int CFG_IDX_BITS = 2;

    // Output queue geometry
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_AW    = 2;
    localparam int OFIFO_CW    = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_FEED_ZERO = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FB_ONE    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FB_TWO    = 2'd2;

    // Control that travels alongside an item through the pipeline
    typedef struct packed {
        logic                 vld;
        logic                 inr;
        logic [CHAN_BITS-1:0] chan;
    } t_tag;

    // Filter coefficients, Q2.x signed
    typedef struct packed {
        logic signed [COEF_BITS-1:0] a0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
    } t_coef;

endpackage

// File: hdl/bwbp_calc.sv
// Biquad arithmetic: four registered products, then sum, round and saturate.
// Depends on bwbp_pkg for t_tag, t_coef and COEF_BITS.
module bwbp_calc #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 21
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bwbp_pkg::t_tag                i_tag,
    input  bwbp_pkg::t_coef               i_coef,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_x1,
    input  logic signed [SAMPLE_BITS-1:0] i_x2,
    input  logic signed [SAMPLE_BITS-1:0] i_y1,
    input  logic signed [SAMPLE_BITS-1:0] i_y2,
    output bwbp_pkg::t_tag                o_tag,
    output logic signed [SAMPLE_BITS-1:0] o_y,
    output logic signed [SAMPLE_BITS-1:0] o_x,
    output logic signed [SAMPLE_BITS-1:0] o_x1,
    output logic signed [SAMPLE_BITS-1:0] o_y1
);

    localparam int PW = bwbp_pkg::COEF_BITS + SAMPLE_BITS;
    localparam int AW = PW + 2;
    localparam logic signed [AW-1:0] RND = AW'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] HI  = (AW'(1) << (SAMPLE_BITS - 1)) - AW'(1);
    localparam logic signed [AW-1:0] LO  = -HI - AW'(1);

    bwbp_pkg::t_tag                r_tag;
    logic signed [PW-1:0]          r_p0, r_p1, r_p2, r_p3;
    logic signed [SAMPLE_BITS-1:0] r_x, r_x1, r_y1;
    logic signed [AW-1:0]          w_acc;
    logic signed [AW-1:0]          w_sh;

    // Hold the item's control, clear on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    // Multiply each tap and carry the history that shifts along
    always_ff @(posedge i_clk) begin
        r_p0 <= $signed(i_coef.a0) * i_x;
        r_p1 <= $signed(i_coef.a0) * i_x2;
        r_p2 <= $signed(i_coef.b1) * i_y1;
        r_p3 <= $signed(i_coef.b2) * i_y2;
        r_x  <= i_x;
        r_x1 <= i_x1;
        r_y1 <= i_y1;
    end

    // Sum, round half up, drop fraction bits
    always_comb begin
        w_acc = AW'(r_p0) - AW'(r_p1) - AW'(r_p2) - AW'(r_p3) + RND;
        w_sh  = w_acc >>> COEF_FRAC_BITS;
    end

    // Saturate to the sample range; out-of-range channels give zero
    always_comb begin
        if (!r_tag.inr) begin
            o_y = '0;
        end else if (w_sh > HI) begin
            o_y = HI[SAMPLE_BITS-1:0];
        end else if (w_sh < LO) begin
            o_y = LO[SAMPLE_BITS-1:0];
        end else begin
            o_y = w_sh[SAMPLE_BITS-1:0];
        end
    end

    assign o_tag = r_tag;
    assign o_x   = r_x;
    assign o_x1  = r_x1;
    assign o_y1  = r_y1;

endmodule

// File: hdl/bwbp_ofifo.sv
// Small result queue that decouples the pipeline from output backpressure.
// Depends on bwbp_pkg for the queue depth and counter widths.
module bwbp_ofifo #(
    parameter int DW = 27
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [DW-1:0]                 i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [DW-1:0]                 o_data,
    output logic [bwbp_pkg::OFIFO_CW-1:0] o_count
);

    logic [DW-1:0]                 r_buf [bwbp_pkg::OFIFO_DEPTH];
    logic [bwbp_pkg::OFIFO_AW-1:0] r_wp, r_rp;
    logic [bwbp_pkg::OFIFO_CW-1:0] r_cnt;
    logic                          w_pop;

    assign o_valid = (r_cnt != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_buf[r_rp];
    assign o_count = r_cnt;

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

    // Advance pointers and track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: hdl/butterworth_bandpass_biquad.sv
// Multi-channel Butterworth bandpass biquad; channel history in one memory.
// Path: a result passes stage A and the calc register, then enters the output queue
// and is offered on the output once it is queued.
// Throughput: one item per cycle while the output queue has room; an item on the same channel
// as the one taken the cycle before waits until that one leaves stage A (history read-modify-write loop).
// Reset (synchronous): coefficients zero, all history reads as zero, queue empty.
module butterworth_bandpass_biquad #(
    parameter int  NUM_CHANNELS   = 8,
    parameter int  SAMPLE_BITS    = 24,
    parameter int  COEF_FRAC_BITS = 21,
    localparam int TDATA_W        = ((bwbp_pkg::CHAN_BITS + SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [TDATA_W-1:0]                i_s_axis_tdata,  // chan, sample_in, zero pad
    // output stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [TDATA_W-1:0]                o_m_axis_tdata,  // chan_out, sample_out, zero pad
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [bwbp_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [bwbp_pkg::COEF_BITS-1:0]    i_cfg_data
);

    localparam int SB  = SAMPLE_BITS;
    localparam int CB  = bwbp_pkg::CHAN_BITS;
    localparam int CAW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int EW  = 4 * SB;
    localparam int QW  = CB + SB;

    // Coefficients
    bwbp_pkg::t_coef r_coef;

    // History memory: {y2, y1, x2, x1} per channel
    logic [EW-1:0]           r_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_hist_vld;
    logic [EW-1:0]           r_rd;
    logic                    r_rd_vld;

    // Input side
    logic [CB-1:0]          w_in_chan;
    logic signed [SB-1:0]   w_in_x;
    logic                   w_in_inr;
    logic [CAW-1:0]         w_raddr;
    logic                   w_hazard;
    logic                   w_space;
    logic                   w_s_acc;
    logic [bwbp_pkg::OFIFO_CW-1:0] w_fill;

    // Stage A
    bwbp_pkg::t_tag         r_a_tag;
    logic signed [SB-1:0]   r_a_x;
    logic [EW-1:0]          w_ent;

    // Writeback forwarding
    logic                   r_wb_vld;
    logic [CB-1:0]          r_wb_chan;
    logic [EW-1:0]          r_wb_ent;

    // Stage B outputs
    bwbp_pkg::t_tag         w_b_tag;
    logic signed [SB-1:0]   w_b_y, w_b_x, w_b_x1, w_b_y1;
    logic                   w_we;
    logic [CAW-1:0]         w_waddr;
    logic [EW-1:0]          w_wdata;

    // Output queue
    logic [QW-1:0]                 w_q_data;
    logic [bwbp_pkg::OFIFO_CW-1:0] w_q_count;

    // Write coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bwbp_pkg::CFG_FEED_ZERO: r_coef.a0 <= i_cfg_data;
                bwbp_pkg::CFG_FB_ONE:    r_coef.b1 <= i_cfg_data;
                bwbp_pkg::CFG_FB_TWO:    r_coef.b2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack input, check channel range
    assign w_in_chan = i_s_axis_tdata[CB-1:0];
    assign w_in_x    = i_s_axis_tdata[CB+SB-1:CB];
    assign w_in_inr  = (32'(w_in_chan) < NUM_CHANNELS);
    assign w_raddr   = CAW'(w_in_chan);

    // Stall a same-channel item right behind one still reading its history
    assign w_hazard = r_a_tag.vld && r_a_tag.inr && (r_a_tag.chan == w_in_chan);
    // Accept only while the queue can hold every item in flight
    assign w_fill   = w_q_count + bwbp_pkg::OFIFO_CW'(r_a_tag.vld)
                    + bwbp_pkg::OFIFO_CW'(w_b_tag.vld);
    assign w_space  = (w_fill < bwbp_pkg::OFIFO_CW'(bwbp_pkg::OFIFO_DEPTH));

    assign o_s_axis_tready = w_space && !w_hazard;
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;

    // History memory: read every cycle, write back finished items
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[w_raddr];
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    // Per-channel valid bits: unwritten history reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
        end else if (w_we) begin
            r_hist_vld[w_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_hist_vld[w_raddr];
    end

    // Stage A: capture transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
        end else begin
            r_a_tag.vld  <= w_s_acc;
            r_a_tag.inr  <= w_in_inr;
            r_a_tag.chan <= w_in_chan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_x <= w_in_x;
    end

    // Forward the entry written at the read edge, else use memory or zero
    always_comb begin
        if (r_wb_vld && (r_wb_chan == r_a_tag.chan)) begin
            w_ent = r_wb_ent;
        end else if (r_rd_vld) begin
            w_ent = r_rd;
        end else begin
            w_ent = '0;
        end
    end

    bwbp_calc #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_a_tag),
        .i_coef  (r_coef),
        .i_x     (r_a_x),
        .i_x1    (w_ent[SB-1:0]),
        .i_x2    (w_ent[2*SB-1:SB]),
        .i_y1    (w_ent[3*SB-1:2*SB]),
        .i_y2    (w_ent[4*SB-1:3*SB]),
        .o_tag   (w_b_tag),
        .o_y     (w_b_y),
        .o_x     (w_b_x),
        .o_x1    (w_b_x1),
        .o_y1    (w_b_y1)
    );

    // Writeback: shift history by one sample
    assign w_we    = w_b_tag.vld && w_b_tag.inr;
    assign w_waddr = CAW'(w_b_tag.chan);
    assign w_wdata = {w_b_y1, w_b_y, w_b_x1, w_b_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_vld <= 1'b0;
        end else begin
            r_wb_vld <= w_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_chan <= w_b_tag.chan;
        r_wb_ent  <= w_wdata;
    end

    // Queue results toward the output
    bwbp_ofifo #(
        .DW (QW)
    ) u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_b_tag.vld),
        .i_data  ({w_b_y, w_b_tag.chan}),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (w_q_data),
        .o_count (w_q_count)
    );

    assign o_m_axis_tdata = TDATA_W'(w_q_data);

`ifndef NO_ASSERTIONS
    // Queue never overflows: the credit check covers all items in flight
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_b_tag.vld |-> (w_q_count < bwbp_pkg::OFIFO_CW'(bwbp_pkg::OFIFO_DEPTH))
                        || (o_m_axis_tvalid && i_m_axis_tready))
        else $error("output queue overflow");

    // An in-range transfer writes its channel history once it has passed stage A and the calc register
    a_writeback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc && w_in_inr |=> ##1 (w_we && (w_b_tag.chan == $past(w_in_chan, 2))))
        else $error("history writeback missing");

    // Results for out-of-range channels (at or beyond NUM_CHANNELS) are zero
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (32'(o_m_axis_tdata[CB-1:0]) >= NUM_CHANNELS)
        |-> (o_m_axis_tdata[CB+SB-1:CB] == '0))
        else $error("nonzero result for unused channel");

    // Nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule

// File: tb/butterworth_bandpass_biquad_test.sv
// Self-checking testbench for butterworth_bandpass_biquad: it streams channel samples in,
// predicts each filtered sample with its own fixed-point biquad and compares the outputs.
// Depends on bwbp_pkg and the butterworth_bandpass_biquad RTL.
`timescale 1ns / 100ps

module butterworth_bandpass_biquad_test;

    localparam int CHAN_BITS    = bwbp_pkg::CHAN_BITS;
    localparam int COEF_BITS    = bwbp_pkg::COEF_BITS;
    localparam int CFG_IDX_BITS = bwbp_pkg::CFG_IDX_BITS;

    localparam int NCH          = 8;
    localparam int SMP_W        = 24;
    localparam int FRAC         = 21;
    localparam int TDATA_W      = ((CHAN_BITS + SMP_W + 7) / 8) * 8;
    localparam int SETTLE_CYC   = 8;
    localparam int DRAIN_CYC    = 16;
    localparam int PHASE_ITEMS  = 150;
    localparam int NUM_PHASES   = 7;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYC     = 150;

    localparam logic [SMP_W-1:0] SMP_MAX = 24'h7FFFFF;
    localparam logic [SMP_W-1:0] SMP_MIN = 24'h800000;
    localparam logic [COEF_BITS-1:0] COEF_ONE  = 24'h200000;
    localparam logic [COEF_BITS-1:0] COEF_HALF = 24'h100000;
    // index past the register list; writes to it must be ignored
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [CHAN_BITS-1:0] chan;
        logic [SMP_W-1:0]     smp;
    } t_bp_result;

    // Bandpass predictor plus the queue of filtered samples still owed by the block
    class t_bandpass_scoreboard;
        logic signed [COEF_BITS-1:0] a0, b1, b2;
        logic signed [SMP_W-1:0] x_one [NCH];
        logic signed [SMP_W-1:0] x_two [NCH];
        logic signed [SMP_W-1:0] y_one [NCH];
        logic signed [SMP_W-1:0] y_two [NCH];
        t_bp_result expected_out [$];
        int errors;
        int n_checked;

        function new();
            a0 = '0;
            b1 = '0;
            b2 = '0;
            for (int i = 0; i < NCH; i++) begin
                x_one[i] = '0;
                x_two[i] = '0;
                y_one[i] = '0;
                y_two[i] = '0;
            end
            errors = 0;
            n_checked = 0;
        endfunction

        function void set_coef(logic [CFG_IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] val);
            case (idx)
                bwbp_pkg::CFG_FEED_ZERO: a0 = val;
                bwbp_pkg::CFG_FB_ONE:    b1 = val;
                bwbp_pkg::CFG_FB_TWO:    b2 = val;
                default: ;
            endcase
        endfunction

        // Run one sample through the channel's biquad and advance its history
        function void note_input(logic [CHAN_BITS-1:0] ch, logic [SMP_W-1:0] smp);
            longint acc;
            logic signed [SMP_W-1:0] x;
            logic signed [SMP_W-1:0] y;
            t_bp_result r;
            x = smp;
            acc = longint'(a0) * longint'(x) - longint'(a0) * longint'(x_two[ch])
                - longint'(b1) * longint'(y_one[ch]) - longint'(b2) * longint'(y_two[ch]);
            // round half up, then floor shift
            acc = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
            if (acc > longint'($signed(SMP_MAX)))
                y = SMP_MAX;
            else if (acc < longint'($signed(SMP_MIN)))
                y = SMP_MIN;
            else
                y = acc[SMP_W-1:0];
            x_two[ch] = x_one[ch];
            x_one[ch] = x;
            y_two[ch] = y_one[ch];
            y_one[ch] = y;
            r.chan = ch;
            r.smp  = y;
            expected_out.push_back(r);
        endfunction

        function void check_result(logic [CHAN_BITS-1:0] ch, logic [SMP_W-1:0] smp);
            t_bp_result e;
            n_checked++;
            if (expected_out.size() == 0) begin
                $display("%0t: unexpected output transfer chan %0d sample %0d",
                         $time, ch, $signed(smp));
                errors++;
                return;
            end
            e = expected_out.pop_front();
            if (e.chan !== ch) begin
                $display("%0t: chan_out mismatch expected %0d actual %0d", $time, e.chan, ch);
                errors++;
            end
            if (e.smp !== smp) begin
                $display("%0t: sample_out mismatch expected %0d actual %0d",
                         $time, $signed(e.smp), $signed(smp));
                errors++;
            end
        endfunction

        function int pending();
            return expected_out.size();
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n  = 1'b0;
    logic                     s_valid  = 1'b0;
    logic [TDATA_W-1:0]       s_data   = '0;
    logic                     m_ready  = 1'b0;
    logic                     cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_idx  = '0;
    logic [COEF_BITS-1:0]     cfg_data = '0;
    wire                      s_ready;
    wire                      m_valid;
    wire  [TDATA_W-1:0]       m_data;

    t_bandpass_scoreboard sb = new();
    int  burst_left = 0;
    int  n_sent     = 0;
    int  n_settings = 0;
    int  rx_cycle   = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;

    butterworth_bandpass_biquad dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),    // chan, sample_in, zero pad
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),    // chan_out, sample_out, zero pad
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one sample and hold it until the transfer; idle between bursts
    task automatic send_item(input logic [CHAN_BITS-1:0] ch, input logic [SMP_W-1:0] smp);
        s_valid <= 1'b1;
        s_data  <= {{(TDATA_W - CHAN_BITS - SMP_W){1'b0}}, smp, ch};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        sb.note_input(ch, smp);
        n_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 7) == 0 ? $urandom_range(8, 20) : $urandom_range(1, 4))
                @(posedge i_clk);
            burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [COEF_BITS-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        sb.set_coef(idx, val);
    endtask

    // Drain the block, then load a new coefficient set (plus a write to the unused index)
    task automatic program_coefs(input logic [COEF_BITS-1:0] a0, input logic [COEF_BITS-1:0] b1,
                                 input logic [COEF_BITS-1:0] b2);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        write_reg(bwbp_pkg::CFG_FEED_ZERO, a0);
        write_reg(bwbp_pkg::CFG_FB_ONE, b1);
        write_reg(bwbp_pkg::CFG_FB_TWO, b2);
        write_reg(CFG_UNUSED, COEF_BITS'($urandom()));
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [COEF_BITS-1:0] extreme_coef();
        case ($urandom_range(0, 4))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return '0;
            3: return COEF_ONE;
            default: return -COEF_ONE;
        endcase
    endfunction

    function automatic logic [SMP_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return SMP_MAX;
                    1: return SMP_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2: return SMP_W'($urandom_range(0, 4095) - 2048);
            default: return SMP_W'($urandom());
        endcase
    endfunction

    // Check output transfers and drive tready: a rotating stall pattern plus one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready)
            sb.check_result(m_data[CHAN_BITS-1:0], m_data[CHAN_BITS +: SMP_W]);
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && sb.n_checked >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYC;
            m_ready <= 1'b0;
        end else begin
            case ((rx_cycle >> 6) % 7)
                0, 1: m_ready <= 1'b1;
                2:    m_ready <= 1'($urandom_range(0, 1));
                3:    m_ready <= ($urandom_range(0, 3) == 0);
                4:    m_ready <= (rx_cycle % 8 != 0);
                5:    m_ready <= ((rx_cycle >> 3) % 2 == 1);
                default: m_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Stimulus
    initial begin
        int                   b2q;
        int                   b1mag;
        logic [COEF_BITS-1:0] a0, b1, b2;
        logic [CHAN_BITS-1:0] ch;

        ch = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset coefficients give zero output while history still fills
        send_item(3'd0, SMP_MAX);
        send_item(3'd7, SMP_MIN);

        // y = x - x[n-2]: full-scale steps, back-to-back on one channel, saturation
        program_coefs(COEF_ONE, '0, '0);
        send_item(3'd3, SMP_MAX);
        send_item(3'd3, SMP_MIN);
        send_item(3'd3, '0);
        send_item(3'd3, '1);
        send_item(3'd0, 24'd5);

        // gain one half: rounding of exact halves in both signs
        program_coefs(COEF_HALF, '0, '0);
        send_item(3'd5, 24'd1);
        send_item(3'd5, -24'd1);
        send_item(3'd5, 24'd3);
        send_item(3'd5, -24'd3);

        // extreme coefficients drive hard saturation on every channel
        program_coefs(SMP_MAX, SMP_MIN, SMP_MAX);
        send_item(3'd1, SMP_MAX);
        send_item(3'd1, SMP_MAX);
        send_item(3'd2, SMP_MIN);
        send_item(3'd2, SMP_MIN);
        for (int c = 0; c < NCH; c++)
            send_item(CHAN_BITS'(c), (c % 2 == 1) ? SMP_MAX : SMP_MIN);

        // random phases: stable filters, wide random and extreme coefficient sets
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 3)
                0: begin
                    b2q   = $urandom_range(1048576, 2076180);
                    b1mag = $urandom_range(0, 2097152 + b2q - 1);
                    a0 = COEF_BITS'((2097152 - b2q) / 2);
                    b1 = $urandom_range(0, 1) ? COEF_BITS'(-b1mag) : COEF_BITS'(b1mag);
                    b2 = COEF_BITS'(b2q);
                end
                1: begin
                    a0 = COEF_BITS'($urandom());
                    b1 = COEF_BITS'($urandom());
                    b2 = COEF_BITS'($urandom());
                end
                default: begin
                    a0 = extreme_coef();
                    b1 = extreme_coef();
                    b2 = extreme_coef();
                end
            endcase
            program_coefs(a0, b1, b2);
            repeat (PHASE_ITEMS) begin
                // stick to the last channel now and then to hit the same-channel stall
                if ($urandom_range(0, 3) != 0)
                    ch = CHAN_BITS'($urandom_range(0, NCH - 1));
                send_item(ch, random_sample());
            end
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("Sent %0d samples across %0d coefficient settings, checked %0d outputs,",
                 n_sent, n_settings, sb.n_checked);
        $display("with random input gaps, output stalls and one long output hold-off.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: butterworth_bandpass_biquad.f
hdl/bwbp_pkg.sv
hdl/bwbp_calc.sv
hdl/bwbp_ofifo.sv
hdl/butterworth_bandpass_biquad.sv
tb/butterworth_bandpass_biquad_test.sv
